[rtl/bdclp_pkg.sv]
// Package for the debounced button with click and long-press detection.
// Holds register indexes, field widths, reset values and shared structs.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package bdclp_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd2;

  // Register and field widths
  localparam int DEBOUNCE_W = 10;
  localparam int LONG_W     = 16;
  localparam int PRESS_MS_W = 16;

  // Register reset values
  localparam logic                  ACTIVE_LOW_RST    = 1'b1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST   = 10'd50;
  localparam logic [LONG_W-1:0]     LONG_PRESS_MS_RST = 16'd1000;

  // Stream data widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = 7 + PRESS_MS_W;
  localparam int OUT_DATA_W = 24;

  // Current register contents
  typedef struct packed {
    logic                  active_low;
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [LONG_W-1:0]     long_press_ms;
  } cfg_t;

  // One result item, first field in the highest bits
  typedef struct packed {
    logic [PRESS_MS_W-1:0] press_ms;
    logic                  long_held;
    logic                  click_pending;
    logic                  ev_released;
    logic                  ev_click;
    logic                  ev_long_press;
    logic                  ev_pressed;
    logic                  pressed;
  } res_t;

endpackage

[rtl/button_debounce_click_long_press.sv]
// Top level of the debounced button with click and long-press detection.
// Depends on bdclp_pkg, bdclp_cfg, bdclp_step and bdclp_oreg.
//
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid/tready           tdata: raw_level, click_read
// m_axis    out        tvalid/tready           tdata: pressed .. press_ms
// cfg       in         cfg_we (no wait)        cfg_index, cfg_data
//
// One item per clock unless the sink stalls: an accepted item updates the state and
// lands in the output register at the same edge, so its result is visible in the next cycle.
// The single output register sets the rate; s_axis_tready drops only while
// that register is full and m_axis_tready is low.
// Reset (rst, synchronous) restores the register defaults and the released
// state; no clearing pass is needed.
`timescale 1ns / 1ps

module button_debounce_click_long_press #(
  parameter int DURATION_BITS = 16,
  parameter int STABLE_BITS   = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] raw_level, [1] click_read, [7:2] zero
  input  logic [bdclp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] pressed, [1] ev_pressed, [2] ev_long_press, [3] ev_click,
  // [4] ev_released, [5] click_pending, [6] long_held, [22:7] press_ms, [23] zero
  output logic [bdclp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [bdclp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdclp_pkg::CFG_DATA_W-1:0] cfg_data
);

  bdclp_pkg::cfg_t cfg;
  bdclp_pkg::res_t res;
  logic            fire;

  assign fire = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  bdclp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Debounce and press tracking
  bdclp_step #(
    .DURATION_BITS (DURATION_BITS),
    .STABLE_BITS   (STABLE_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .raw_level  (s_axis_tdata[0]),
    .click_read (s_axis_tdata[1]),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register
  bdclp_oreg u_oreg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res      (res),
    .can_load (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule

[rtl/bdclp_cfg.sv]
// Configuration registers of the button block.
// Depends on bdclp_pkg for indexes, widths and reset values.
`timescale 1ns / 1ps

module bdclp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdclp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdclp_pkg::CFG_DATA_W-1:0] cfg_data,
  output bdclp_pkg::cfg_t                  cfg
);

  // Write the addressed register; other indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low    <= bdclp_pkg::ACTIVE_LOW_RST;
      cfg.debounce_ms   <= bdclp_pkg::DEBOUNCE_MS_RST;
      cfg.long_press_ms <= bdclp_pkg::LONG_PRESS_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdclp_pkg::CFG_ACTIVE_LOW:    cfg.active_low    <= cfg_data[0];
        bdclp_pkg::CFG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data[bdclp_pkg::DEBOUNCE_W-1:0];
        bdclp_pkg::CFG_LONG_PRESS_MS: cfg.long_press_ms <= cfg_data[bdclp_pkg::LONG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/bdclp_step.sv]
// Per-tick debounce and press tracking: state registers plus next-state logic.
// Depends on bdclp_pkg for cfg_t, res_t and field widths.
`timescale 1ns / 1ps

module bdclp_step #(
  parameter int DURATION_BITS = 16,
  parameter int STABLE_BITS   = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic            raw_level,
  input  logic            click_read,
  input  bdclp_pkg::cfg_t cfg,
  output bdclp_pkg::res_t res
);

  localparam int SCMP_W = (STABLE_BITS > bdclp_pkg::DEBOUNCE_W) ?
                          STABLE_BITS : bdclp_pkg::DEBOUNCE_W;
  localparam int DCMP_W = (DURATION_BITS > bdclp_pkg::LONG_W) ?
                          DURATION_BITS : bdclp_pkg::LONG_W;

  logic                     last_raw, last_raw_next;
  logic                     debounced, debounced_next;
  logic [STABLE_BITS-1:0]   stable_ticks, stable_ticks_next;
  logic [DURATION_BITS-1:0] press_ticks, press_ticks_next;
  logic                     long_marked, long_marked_next;
  logic                     click_flag, click_flag_next;

  logic                     level;
  logic [DURATION_BITS-1:0] press_inc;
  logic                     elapsed;
  logic                     inc_long;
  logic                     final_long;
  logic [DCMP_W-1:0]        press_ext;
  logic                     ev_p, ev_l, ev_c, ev_r;

  // Compute the next state and this tick's result
  always_comb begin
    level             = raw_level ^ cfg.active_low;
    last_raw_next     = level;
    debounced_next    = debounced;
    long_marked_next  = long_marked;
    click_flag_next   = click_flag;
    ev_p              = 1'b0;
    ev_l              = 1'b0;
    ev_c              = 1'b0;
    ev_r              = 1'b0;

    // Restart the stability count on a level change, else saturate upward
    if (level != last_raw) begin
      stable_ticks_next = '0;
    end else if (stable_ticks != '1) begin
      stable_ticks_next = stable_ticks + 1'b1;
    end else begin
      stable_ticks_next = stable_ticks;
    end

    // Advance the press timer while held
    if (debounced && press_ticks != '1) begin
      press_inc = press_ticks + 1'b1;
    end else begin
      press_inc = press_ticks;
    end
    press_ticks_next = press_inc;

    elapsed  = SCMP_W'(stable_ticks_next) > SCMP_W'(cfg.debounce_ms);
    inc_long = DCMP_W'(press_inc) >= DCMP_W'(cfg.long_press_ms);

    // Accept a new level or check for long press once debounce has elapsed
    if (elapsed) begin
      if (level != debounced) begin
        debounced_next   = level;
        press_ticks_next = '0;
        if (level) begin
          long_marked_next = 1'b0;
          ev_p             = 1'b1;
        end else begin
          if (inc_long) begin
            if (!long_marked) begin
              long_marked_next = 1'b1;
              ev_l             = 1'b1;
            end
          end else begin
            click_flag_next = 1'b1;
            ev_c            = 1'b1;
          end
          ev_r = 1'b1;
        end
      end else if (debounced && !long_marked && inc_long) begin
        long_marked_next = 1'b1;
        ev_l             = 1'b1;
      end
    end

    // Report the click flag, then clear it on request
    res.click_pending = click_flag_next;
    if (click_read) begin
      click_flag_next = 1'b0;
    end

    press_ext  = DCMP_W'(press_ticks_next);
    final_long = press_ext >= DCMP_W'(cfg.long_press_ms);

    res.pressed       = debounced_next;
    res.ev_pressed    = ev_p;
    res.ev_long_press = ev_l;
    res.ev_click      = ev_c;
    res.ev_released   = ev_r;
    res.long_held     = debounced_next & final_long;
    if (!debounced_next) begin
      res.press_ms = '0;
    end else if (press_ext > DCMP_W'({bdclp_pkg::PRESS_MS_W{1'b1}})) begin
      res.press_ms = '1;
    end else begin
      res.press_ms = press_ext[bdclp_pkg::PRESS_MS_W-1:0];
    end
  end

  // Hold state until an item is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      debounced    <= 1'b0;
      stable_ticks <= '0;
      press_ticks  <= '0;
      long_marked  <= 1'b0;
      click_flag   <= 1'b0;
    end else if (fire) begin
      last_raw     <= last_raw_next;
      debounced    <= debounced_next;
      stable_ticks <= stable_ticks_next;
      press_ticks  <= press_ticks_next;
      long_marked  <= long_marked_next;
      click_flag   <= click_flag_next;
    end
  end

endmodule

[rtl/bdclp_oreg.sv]
// Output register of the button block: holds one result item for the sink.
// Depends on bdclp_pkg for res_t and the output data width.
`timescale 1ns / 1ps

module bdclp_oreg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  bdclp_pkg::res_t                  res,
  output logic                             can_load,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bdclp_pkg::OUT_DATA_W-1:0] m_tdata
);

  bdclp_pkg::res_t data;

  // Take a new item whenever the register is empty or being drained
  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign m_tdata = bdclp_pkg::OUT_DATA_W'(data);

endmodule
